FILE: rtl/core/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

   // Map geometry: one word holds the used bits of 64 consecutive blocks.
   localparam int WORD_W         = 64;
   localparam int POS_W          = 6;
   localparam int IDX_W          = 12;
   localparam int CNT_W          = 13;
   localparam int KIND_W         = 3;
   localparam int STATUS_W       = 2;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 32;
   localparam int CSR_INDEX_W    = 1;

   // Cap on the number of map bits, one above the largest value of a 13-bit total.
   localparam int MAP_BITS_CAP   = 8192;
   localparam int DEF_MAX_BLOCKS = 4096;
   localparam int TOTAL_RESET    = 4096;
   localparam int RESERVED_RESET = 0;

   localparam logic [KIND_W-1:0] KIND_FORMAT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOCATE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TEST     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESERVED = 1'b1;

   // Mask of the bit positions b of a word whose block number base + b lies below lim.
   function automatic logic [WORD_W-1:0] low_mask(input logic [CNT_W-1:0] base,
                                                  input logic [CNT_W-1:0] lim);
      logic [CNT_W-1:0] d;
      logic [WORD_W-1:0] m;
      d = lim - base;
      if (lim <= base) begin
         m = '0;
      end else if (d >= CNT_W'(WORD_W)) begin
         m = '1;
      end else begin
         m = ~({WORD_W{1'b1}} << d[POS_W-1:0]);
      end
      return m;
   endfunction

endpackage

FILE: rtl/core/block_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// Format writes every map word in turn, then sets the free count to total less reserved.
// Allocate reads one map word per cycle through the single map read port and a
// single first-zero finder, at most ceil(total/64) words, none if the free count is zero.
// Release, test, write read, then test or change the bit; range or kind errors skip both.
// One request is worked on at a time, and a response not yet taken holds off the next one.
// Synchronous reset clears the map at once through per-word valid flags: no clearing pass.

module block_bitmap_allocator_unit #(
   parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] kind, [14:3] block_index, [15] bit_value
   input  logic [bba_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [11:0] result_index, [12] bit_read, [25:13] free_left, [27:26] status, rest zero
   output logic [bba_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [bba_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bba_pkg::CNT_W-1:0]         csr_wr_data
);

   localparam int NBITS  = (MAX_BLOCKS < bba_pkg::MAP_BITS_CAP) ? MAX_BLOCKS
                                                                 : bba_pkg::MAP_BITS_CAP;
   localparam int NWORDS = (NBITS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int CW     = AW + 1;
   localparam int FREE_RESET = (MAX_BLOCKS < bba_pkg::TOTAL_RESET) ? MAX_BLOCKS
                                                                   : bba_pkg::TOTAL_RESET;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FORMAT = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_UPDATE = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   localparam int CNT_W = bba_pkg::CNT_W;
   localparam int IDX_W = bba_pkg::IDX_W;
   localparam int WORD_W = bba_pkg::WORD_W;
   localparam int POS_W = bba_pkg::POS_W;

   logic [2:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               total_ff, reserved_ff;
   logic [CNT_W-1:0]               free_ff, free_in;
   logic [bba_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic                           bv_ff, bv_in;
   logic [IDX_W-1:0]               res_idx_ff, res_idx_in;
   logic                           bit_ff, bit_in;
   logic [bba_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic                           pend_ff, pend_in;
   logic [AW-1:0]                  pend_word_ff, pend_word_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]               tot;
   logic [CNT_W-1:0]               res_cnt;
   logic [CNT_W:0]                 tot_round;
   logic [7:0]                     limit;
   logic                           req_fire;
   logic [bba_pkg::KIND_W-1:0]     req_kind;
   logic [IDX_W-1:0]               req_idx;
   logic                           issue;
   logic [CNT_W-1:0]               pend_base;
   logic [WORD_W-1:0]              scan_word;
   logic                           zero_found;
   logic [POS_W-1:0]               zero_pos;
   logic [6:0]                     idx_word;
   logic [WORD_W-1:0]              idx_bit;

   logic                           map_wr_en;
   logic [AW-1:0]                  map_wr_addr;
   logic [WORD_W-1:0]              map_wr_data;
   logic                           map_rd_en;
   logic [AW-1:0]                  map_rd_addr;
   logic [WORD_W-1:0]              map_rd_data;

   bba_map #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .NWORDS     (NWORDS),
      .AW         (AW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   bba_ffz u_ffz (
      .word_in (scan_word),
      .found   (zero_found),
      .pos     (zero_pos)
   );

   assign tot = ({1'b0, total_ff} > (CNT_W + 1)'(NBITS)) ? CNT_W'(NBITS) : total_ff;
   assign res_cnt   = (reserved_ff > tot) ? tot : reserved_ff;
   assign tot_round = {1'b0, tot} + (CNT_W + 1)'(WORD_W - 1);
   assign limit     = 8'(tot_round >> POS_W);

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_kind   = req_tdata[2:0];
   assign req_idx    = req_tdata[14:3];

   assign pend_base  = CNT_W'({pend_word_ff, 6'd0});
   // Bits at or above the block total count as used, so the finder skips them.
   assign scan_word  = map_rd_data | ~bba_pkg::low_mask(pend_base, tot);
   assign issue      = (state_ff == S_SCAN) && (8'(cnt_ff) < limit)
                       && !(pend_ff && zero_found);

   assign idx_word   = {1'b0, idx_ff[IDX_W-1:POS_W]};
   assign idx_bit    = WORD_W'(1) << idx_ff[POS_W-1:0];

   always_comb begin
      state_in     = state_ff;
      free_in      = free_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      bv_in        = bv_ff;
      res_idx_in   = res_idx_ff;
      bit_in       = bit_ff;
      status_in    = status_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_word_in = pend_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      map_wr_en    = 1'b0;
      map_wr_addr  = cnt_ff[AW-1:0];
      map_wr_data  = bba_pkg::low_mask(CNT_W'({cnt_ff, 6'd0}), res_cnt);
      map_rd_en    = 1'b0;
      map_rd_addr  = cnt_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in    = req_kind;
               idx_in     = req_idx;
               bv_in      = req_tdata[15];
               res_idx_in = '0;
               bit_in     = 1'b0;
               status_in  = bba_pkg::STATUS_OK;
               cnt_in     = '0;
               case (req_kind)
                  bba_pkg::KIND_FORMAT: begin
                     state_in = S_FORMAT;
                  end
                  bba_pkg::KIND_ALLOCATE: begin
                     status_in = bba_pkg::STATUS_NO_SPACE;
                     state_in  = (free_ff == '0) ? S_DONE : S_SCAN;
                  end
                  bba_pkg::KIND_RELEASE, bba_pkg::KIND_TEST, bba_pkg::KIND_WRITE: begin
                     res_idx_in = req_idx;
                     if ({1'b0, req_idx} >= tot) begin
                        status_in = bba_pkg::STATUS_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_FORMAT: begin
            map_wr_en = 1'b1;
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NWORDS - 1)) begin
               free_in  = tot - res_cnt;
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            // One word is read per cycle while the word read before it is checked.
            map_rd_en    = issue;
            pend_in      = issue;
            pend_word_in = cnt_ff[AW-1:0];
            cnt_in       = cnt_ff + CW'(issue);
            map_wr_addr  = pend_word_ff;
            map_wr_data  = map_rd_data | (WORD_W'(1) << zero_pos);
            if (pend_ff && zero_found) begin
               map_wr_en  = 1'b1;
               free_in    = free_ff - CNT_W'(1);
               res_idx_in = IDX_W'({pend_word_ff, zero_pos});
               status_in  = bba_pkg::STATUS_OK;
               state_in   = S_DONE;
            end else if (!issue) begin
               state_in   = S_DONE;
            end
         end
         S_READ: begin
            map_rd_en   = 1'b1;
            map_rd_addr = idx_word[AW-1:0];
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            map_wr_addr = idx_word[AW-1:0];
            state_in    = S_DONE;
            case (kind_ff)
               bba_pkg::KIND_TEST: begin
                  bit_in = map_rd_data[idx_ff[POS_W-1:0]];
               end
               bba_pkg::KIND_RELEASE: begin
                  map_wr_en   = 1'b1;
                  map_wr_data = map_rd_data & ~idx_bit;
                  if (free_ff < tot) begin
                     free_in = free_ff + CNT_W'(1);
                  end
               end
               default: begin
                  map_wr_en   = 1'b1;
                  map_wr_data = bv_ff ? (map_rd_data | idx_bit) : (map_rd_data & ~idx_bit);
               end
            endcase
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = bba_pkg::RSP_DATA_W'({status_ff, free_ff, bit_ff, res_idx_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= CNT_W'(bba_pkg::TOTAL_RESET);
         reserved_ff  <= CNT_W'(bba_pkg::RESERVED_RESET);
         free_ff      <= CNT_W'(FREE_RESET);
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == bba_pkg::CSR_TOTAL) begin
            total_ff <= csr_wr_data;
         end
         if (csr_wr_en && csr_index == bba_pkg::CSR_RESERVED) begin
            reserved_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      idx_ff       <= idx_in;
      bv_ff        <= bv_in;
      res_idx_ff   <= res_idx_in;
      bit_ff       <= bit_in;
      status_ff    <= status_in;
      pend_word_ff <= pend_word_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, free_ff} <= (CNT_W + 1)'(NBITS))
      else $error("free count exceeds the map size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != S_IDLE)
      else $error("request accepted without leaving idle");

   a_alloc_full: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_kind == bba_pkg::KIND_ALLOCATE && free_ff == '0
      |=> state_ff == S_DONE && status_ff == bba_pkg::STATUS_NO_SPACE)
      else $error("allocate with zero free count did not report no space");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      map_wr_en |-> state_ff == S_FORMAT || state_ff == S_SCAN || state_ff == S_UPDATE)
      else $error("map written outside a working state");

   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && (!rsp_valid_ff || rsp_tready) |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished request not handed to the result register");

endmodule

FILE: rtl/core/bba_map.sv
`timescale 1ns / 1ps

module bba_map #(
   parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS,
   parameter int NWORDS     = ((MAX_BLOCKS < bba_pkg::MAP_BITS_CAP) ? MAX_BLOCKS
                               : bba_pkg::MAP_BITS_CAP) / bba_pkg::WORD_W
                              + (((((MAX_BLOCKS < bba_pkg::MAP_BITS_CAP) ? MAX_BLOCKS
                               : bba_pkg::MAP_BITS_CAP) % bba_pkg::WORD_W) != 0) ? 1 : 0),
   parameter int AW         = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bba_pkg::WORD_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [bba_pkg::WORD_W-1:0]  rd_data
);

   logic [bba_pkg::WORD_W-1:0] mem [NWORDS];
   logic [NWORDS-1:0]          valid_ff;
   logic [bba_pkg::WORD_W-1:0] rd_data_ff;
   logic                       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // A word never written since reset reads as all free.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/core/bba_ffz.sv
`timescale 1ns / 1ps

module bba_ffz (
   input  logic [bba_pkg::WORD_W-1:0] word_in,
   output logic                       found,
   output logic [bba_pkg::POS_W-1:0]  pos
);

   localparam int NBYTES = bba_pkg::WORD_W / 8;

   logic [NBYTES-1:0] byte_free;
   logic [2:0]        byte_sel;
   logic [7:0]        sel_byte;
   logic [2:0]        bit_sel;

   // Two levels of eight: first the lowest byte holding a clear bit, then the bit.
   always_comb begin
      for (int b = 0; b < NBYTES; b++) begin
         byte_free[b] = ~&word_in[8*b +: 8];
      end
      byte_sel = '0;
      for (int b = NBYTES - 1; b >= 0; b--) begin
         if (byte_free[b]) begin
            byte_sel = 3'(b);
         end
      end
      sel_byte = word_in[8*byte_sel +: 8];
      bit_sel  = '0;
      for (int k = 7; k >= 0; k--) begin
         if (!sel_byte[k]) begin
            bit_sel = 3'(k);
         end
      end
   end

   assign found = |byte_free;
   assign pos   = {byte_sel, bit_sel};

endmodule
